[rtl/leveled_slot_pool_allocator_defines.svh]
// assertion macros used by the asserting top-level file
`ifndef LEVELED_SLOT_POOL_ALLOCATOR_DEFINES_SVH
`define LEVELED_SLOT_POOL_ALLOCATOR_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define LSPA_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lspa: implication failed");

// next-cycle implication, sampled on clk, off while in reset
`define LSPA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lspa: next-cycle implication failed");

`endif

[rtl/lspa_pkg.sv]
package lspa_pkg;

    // widths fixed by the request and result fields
    localparam int OP_W     = 2;
    localparam int LEVEL_W  = 2;
    localparam int SLOT_W   = 4;
    localparam int NOW_W    = 32;
    localparam int MASK_W   = 16;
    localparam int MAP_W    = 32;
    localparam int HOLD_W   = 8;

    // slots that the enable and level registers can describe
    localparam int MAP_SLOTS = 16;
    localparam int LEVEL_COUNT = 4;

    localparam int SLOT_COUNT_DEF = 16;
    localparam int TIME_BITS_DEF  = 32;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [HOLD_W-1:0] HOLD_RESET = 8'd5;

    // configuration register indexes
    localparam logic [1:0] REG_ENABLE    = 2'd0;
    localparam logic [1:0] REG_LEVEL_MAP = 2'd1;
    localparam logic [1:0] REG_HOLD      = 2'd2;
    localparam int PADDR_W = 4;

    typedef enum logic [OP_W-1:0] {
        OP_ACQUIRE  = 2'd0,
        OP_RELEASE  = 2'd1,
        OP_SWEEP    = 2'd2,
        OP_RESERVED = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        K_ACQ      = 3'd0,
        K_ACQ_FAIL = 3'd1,
        K_REL      = 3'd2,
        K_SWEEP    = 3'd3,
        K_NOP      = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t               kind;
        logic [LEVEL_W-1:0]  level;
        logic [SLOT_W-1:0]   slot_index;
        logic                was_used;
        logic [NOW_W-1:0]    now_time;
    } cmd_t;

    typedef struct packed {
        logic                status;
        logic [SLOT_W-1:0]   granted_slot;
        logic [MASK_W-1:0]   closed_mask;
    } res_t;

    typedef struct packed {
        logic [MASK_W-1:0] enable;
        logic [MAP_W-1:0]  level_map;
        logic [HOLD_W-1:0] hold;
    } cfg_t;

endpackage

[rtl/lspa_queue.sv]
module lspa_queue #(
    parameter type T = logic,
    parameter int DEPTH = lspa_pkg::QUEUE_DEPTH
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  T     wdata,
    output logic full,
    input  logic pop,
    output T     rdata,
    output logic empty
);

    localparam int AW = $clog2(DEPTH);

    T               mem_reg [DEPTH];
    logic [AW-1:0]  wr_reg;
    logic [AW-1:0]  wr_next;
    logic [AW-1:0]  rd_reg;
    logic [AW-1:0]  rd_next;
    logic [AW:0]    cnt_reg;
    logic [AW:0]    cnt_next;
    logic           push_ok;
    logic           pop_ok;

    assign full    = (cnt_reg == (AW+1)'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign push_ok = push && !full;
    assign pop_ok  = pop && !empty;
    assign rdata   = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = push_ok ? wr_reg + 1'b1 : wr_reg;
        rd_next  = pop_ok ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg;
        unique case ({push_ok, pop_ok})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem_reg[wr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

[rtl/lspa_front.sv]
module lspa_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [lspa_pkg::OP_W-1:0]     op,
    input  logic [lspa_pkg::LEVEL_W-1:0]  level,
    input  logic [lspa_pkg::SLOT_W-1:0]   slot_index,
    input  logic                          was_used,
    input  logic [lspa_pkg::NOW_W-1:0]    now_time,
    input  logic                          cmd_pop,
    output lspa_pkg::cmd_t                cmd,
    output logic                          cmd_empty
);

    lspa_pkg::cmd_t cmd_in;
    logic           level_ok;

    // a level with no slots behind it can only fail
    assign level_ok = int'(level) < lspa_pkg::LEVEL_COUNT;

    always_comb
    begin
        cmd_in.level      = level;
        cmd_in.slot_index = slot_index;
        cmd_in.was_used   = was_used;
        cmd_in.now_time   = now_time;
        unique case (op)
            lspa_pkg::OP_ACQUIRE: cmd_in.kind = level_ok ? lspa_pkg::K_ACQ
                                                         : lspa_pkg::K_ACQ_FAIL;
            lspa_pkg::OP_RELEASE: cmd_in.kind = lspa_pkg::K_REL;
            lspa_pkg::OP_SWEEP:   cmd_in.kind = lspa_pkg::K_SWEEP;
            default:              cmd_in.kind = lspa_pkg::K_NOP;
        endcase
    end

    lspa_queue #(
        .T     (lspa_pkg::cmd_t),
        .DEPTH (lspa_pkg::QUEUE_DEPTH)
    ) u_cmd_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (cmd_in),
        .full  (full),
        .pop   (cmd_pop),
        .rdata (cmd),
        .empty (cmd_empty)
    );

endmodule

[rtl/lspa_back.sv]
module lspa_back #(
    parameter int SLOT_COUNT = lspa_pkg::SLOT_COUNT_DEF,
    parameter int TIME_BITS  = lspa_pkg::TIME_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  lspa_pkg::cfg_t cfg,
    input  lspa_pkg::cmd_t cmd,
    input  logic           cmd_empty,
    output logic           cmd_pop,
    input  logic           res_full,
    output logic           res_push,
    output lspa_pkg::res_t res
);

    // slots beyond the register map never become busy or connected
    localparam int POOL = (SLOT_COUNT < lspa_pkg::MAP_SLOTS) ? SLOT_COUNT
                                                             : lspa_pkg::MAP_SLOTS;
    localparam int STAMP_W = (TIME_BITS < lspa_pkg::NOW_W) ? TIME_BITS : lspa_pkg::NOW_W;
    localparam bit WIDE_TIME = TIME_BITS > lspa_pkg::NOW_W;

    logic [POOL-1:0]     busy_reg;
    logic [POOL-1:0]     busy_next;
    logic [POOL-1:0]     conn_reg;
    logic [POOL-1:0]     conn_next;
    logic [STAMP_W-1:0]  stamp_reg [POOL];
    logic [POOL-1:0]     stamp_we;

    logic [STAMP_W-1:0]  now_s;
    logic [POOL-1:0]     cand;
    logic [POOL-1:0]     first;
    logic [POOL-1:0]     hit;
    logic [POOL-1:0]     closing;
    logic [STAMP_W:0]    diff [POOL];
    logic [lspa_pkg::SLOT_W-1:0]  gidx;
    logic [lspa_pkg::LEVEL_W-1:0] slot_lvl [POOL];

    assign cmd_pop  = !cmd_empty && !res_full;
    assign res_push = cmd_pop;
    assign now_s    = cmd.now_time[STAMP_W-1:0];

    always_comb
    begin
        for (int i = 0; i < POOL; i++)
        begin
            slot_lvl[i] = cfg.level_map[2*i +: 2];
            cand[i] = cfg.enable[i] && !busy_reg[i] && (slot_lvl[i] == cmd.level)
                      && (int'(slot_lvl[i]) < lspa_pkg::LEVEL_COUNT);
            hit[i]  = (cmd.slot_index == lspa_pkg::SLOT_W'(i));
            // extra top bit is the borrow of the wrapping difference
            diff[i] = {1'b0, now_s} - {1'b0, stamp_reg[i]};
            closing[i] = !busy_reg[i] && conn_reg[i]
                         && ((WIDE_TIME && diff[i][STAMP_W])
                             || (diff[i][STAMP_W-1:0] > STAMP_W'(cfg.hold)));
        end
    end

    // lowest free candidate, then its index
    assign first = cand & (~cand + POOL'(1));

    always_comb
    begin
        gidx = '0;
        for (int i = 0; i < POOL; i++)
        begin
            if (first[i])
            begin
                gidx = gidx | lspa_pkg::SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        conn_next = conn_reg;
        stamp_we  = '0;
        res       = '0;
        if (cmd_pop)
        begin
            unique case (cmd.kind)
                lspa_pkg::K_ACQ:
                begin
                    if (|cand)
                    begin
                        busy_next        = busy_reg | first;
                        res.granted_slot = gidx;
                    end
                    else
                    begin
                        res.status = 1'b1;
                    end
                end
                lspa_pkg::K_ACQ_FAIL:
                begin
                    res.status = 1'b1;
                end
                lspa_pkg::K_REL:
                begin
                    busy_next = busy_reg & ~(hit & busy_reg);
                    if (cmd.was_used)
                    begin
                        conn_next = conn_reg | (hit & busy_reg);
                        stamp_we  = hit & busy_reg;
                    end
                end
                lspa_pkg::K_SWEEP:
                begin
                    conn_next       = conn_reg & ~closing;
                    res.closed_mask = lspa_pkg::MASK_W'(closing);
                end
                default:
                begin
                    res = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < POOL; i++)
        begin
            if (stamp_we[i])
            begin
                stamp_reg[i] <= now_s;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= '0;
            conn_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            conn_reg <= conn_next;
        end
    end

endmodule

[rtl/leveled_slot_pool_allocator.sv]
// leveled slot pool allocator
// requests enter through push/full: acquire a slot of a level, release a slot
// (optionally stamping it connected at now_time), or sweep idle connected slots
// results leave through empty/pop, one per request, in request order
// configuration sits behind an apb-style port; write it only while the block is
// idle. registers: enable mask at 0x0, level map at 0x4, hold limit at 0x8
// a request is classified as it is accepted into a two-entry command queue,
// executed from the queue head when the result queue has room, and its result
// is registered in the result queue, whose head drives the result ports
// throughput is one request per cycle while the result queue has room, set by
// the executor (first-free priority pick and one idle comparator per slot),
// which handles each request combinationally, feeding a two-entry result queue
// when pop stays low the result queue fills, the executor holds, then the
// command queue fills and full rises; nothing is dropped
// reset empties both queues, frees and disconnects every slot, and sets the
// registers to enable 0, level map 0 and hold limit 5
`include "leveled_slot_pool_allocator_defines.svh"

module leveled_slot_pool_allocator #(
    parameter int SLOT_COUNT = lspa_pkg::SLOT_COUNT_DEF,
    parameter int TIME_BITS  = lspa_pkg::TIME_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [lspa_pkg::OP_W-1:0]      op,
    input  logic [lspa_pkg::LEVEL_W-1:0]   level,
    input  logic [lspa_pkg::SLOT_W-1:0]    slot_index,
    input  logic                           was_used,
    input  logic [lspa_pkg::NOW_W-1:0]     now_time,
    output logic                           empty,
    input  logic                           pop,
    output logic                           status,
    output logic [lspa_pkg::SLOT_W-1:0]    granted_slot,
    output logic [lspa_pkg::MASK_W-1:0]    closed_mask,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lspa_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    logic [lspa_pkg::MASK_W-1:0] enable_reg;
    logic [lspa_pkg::MAP_W-1:0]  level_map_reg;
    logic [lspa_pkg::HOLD_W-1:0] hold_reg;
    logic [1:0]                  reg_idx;
    logic                        wr_en;
    lspa_pkg::cfg_t              cfg;

    lspa_pkg::cmd_t cmd;
    logic           cmd_empty;
    logic           cmd_pop;
    lspa_pkg::res_t res_in;
    lspa_pkg::res_t res_out;
    logic           res_push;
    logic           res_full;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (reg_idx)
            lspa_pkg::REG_ENABLE:    prdata = 32'(enable_reg);
            lspa_pkg::REG_LEVEL_MAP: prdata = level_map_reg;
            lspa_pkg::REG_HOLD:      prdata = 32'(hold_reg);
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= '0;
            level_map_reg <= '0;
            hold_reg      <= lspa_pkg::HOLD_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                lspa_pkg::REG_ENABLE:    enable_reg    <= pwdata[lspa_pkg::MASK_W-1:0];
                lspa_pkg::REG_LEVEL_MAP: level_map_reg <= pwdata;
                lspa_pkg::REG_HOLD:      hold_reg      <= pwdata[lspa_pkg::HOLD_W-1:0];
                default:                 hold_reg      <= hold_reg;
            endcase
        end
    end

    assign cfg.enable    = enable_reg;
    assign cfg.level_map = level_map_reg;
    assign cfg.hold      = hold_reg;

    lspa_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .op         (op),
        .level      (level),
        .slot_index (slot_index),
        .was_used   (was_used),
        .now_time   (now_time),
        .cmd_pop    (cmd_pop),
        .cmd        (cmd),
        .cmd_empty  (cmd_empty)
    );

    lspa_back #(
        .SLOT_COUNT (SLOT_COUNT),
        .TIME_BITS  (TIME_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd       (cmd),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in)
    );

    lspa_queue #(
        .T     (lspa_pkg::res_t),
        .DEPTH (lspa_pkg::QUEUE_DEPTH)
    ) u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_in),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_out),
        .empty (empty)
    );

    assign status       = res_out.status;
    assign granted_slot = res_out.granted_slot;
    assign closed_mask  = res_out.closed_mask;

    // executor never writes into a full result queue
    `LSPA_ASSERT_IMPLY(a_res_no_overflow, res_push, !res_full)
    // a failed acquire carries no slot and no closed mask
    `LSPA_ASSERT_IMPLY(a_fail_clean, !empty && status, granted_slot == '0 && closed_mask == '0)
    // an accepted request is still queued at the next edge
    `LSPA_ASSERT_NEXT(a_cmd_held, push && !full, !cmd_empty)

endmodule
